### rtl/lws_pkg.sv
// Shared types and constants for the latency window statistics block.
// No dependencies; rtl/latency_window_statistics.sv and the testbench import this package.
package lws_pkg;

  localparam int TIME_BITS      = 48;
  localparam int AVG_BITS       = TIME_BITS + 8;
  localparam int SCNT_BITS      = 11;
  localparam int RING_DEPTH_DEF = 1024;
  localparam int PCT_NUM        = 95;
  localparam int PCT_DEN        = 100;
  localparam int PCT_BITS       = 7;

  localparam logic [TIME_BITS-1:0] KEEP_AGE_RESET = TIME_BITS'(600000);

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_END   = 2'd1,
    CMD_CULL  = 2'd2,
    CMD_QUERY = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t                 cmd;
    logic [TIME_BITS-1:0] time_stamp;
    logic [TIME_BITS-1:0] window_age;
  } item_t;

  typedef struct packed {
    logic                 accepted;
    logic [SCNT_BITS-1:0] sample_count;
    logic [TIME_BITS-1:0] min_elapsed;
    logic [TIME_BITS-1:0] max_elapsed;
    logic [AVG_BITS-1:0]  average_fx;
    logic [TIME_BITS-1:0] pct95_elapsed;
  } result_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_SCAN_END,
    ST_STAT_RD,
    ST_STAT_ACC,
    ST_RANK_GO,
    ST_PCT_RD,
    ST_PCT_ACC,
    ST_AVG_GO,
    ST_AVG_WAIT
  } state_t;

endpackage

### rtl/latency_window_statistics.sv
// Latency monitor for one counter: open/close samples, ring of results,
// cull and window query. Uses lws_pkg types and the lws_div divider.
//
// A user should know first: the block takes one command word when start is
// high and busy is low, and returns exactly one result word, marked by done
// for a single cycle, which the receiver must take then. Start and end words
// are handled at the edge that takes them, with done in the next cycle, and
// busy never rises for them. Cull walks the ring from the oldest entry, one
// entry per read state and check state (one read port, registered read data).
// A query does the same walk to find the window start, then a statistics
// pass of read and accumulate steps over the n window samples, a rank step to
// form the percentile rank (reciprocal multiply by the constant), a 95th
// percentile search that makes one pass over the window per time bit
// (bit-wise search on the value), and a final average division in the
// lws_div divider, one quotient bit per cycle over a dividend of time bits +
// count bits + 8 bits. The ring needs no clearing after reset; configuration
// writes of keep_age are taken at any edge with cfg_we high and rst low.
module latency_window_statistics #(
  parameter int RING_DEPTH = lws_pkg::RING_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  lws_pkg::item_t                item,
  output logic                          busy,
  output logic                          done,
  output lws_pkg::result_t              result,
  input  logic                          cfg_we,
  input  logic [lws_pkg::TIME_BITS-1:0] cfg_wdata
);

  import lws_pkg::*;

  localparam int AW   = $clog2(RING_DEPTH);
  localparam int CW   = $clog2(RING_DEPTH + 1);
  localparam int SUMW = TIME_BITS + CW;
  localparam int DW   = SUMW + 8;
  localparam int VW   = (CW > PCT_BITS) ? CW : PCT_BITS;
  localparam int RW   = CW + PCT_BITS;
  // rank = rank_num / PCT_DEN as a multiply by a rounded-up reciprocal;
  // seven spare shift bits keep it exact over the whole rank_num range
  localparam int     RS   = RW + 7;
  localparam int     MW   = RS - 6;
  localparam longint RMUL = ((longint'(1) << RS) + PCT_DEN - 1) / PCT_DEN;

  state_t state, state_next;

  logic [TIME_BITS-1:0] keep_age;
  logic [TIME_BITS-1:0] open_start;
  logic [AW-1:0]        head;
  logic [CW-1:0]        count;
  cmd_t                 cmd_r;
  logic [TIME_BITS-1:0] cutoff;
  logic [AW-1:0]        ptr;
  logic [AW-1:0]        win_ptr;
  logic [CW-1:0]        idx;
  logic [CW-1:0]        nwin;
  logic [TIME_BITS-1:0] mn;
  logic [TIME_BITS-1:0] mx;
  logic [SUMW-1:0]      sum;
  logic [CW-1:0]        rank;
  logic [TIME_BITS-1:0] ans;
  logic [TIME_BITS-1:0] pbit;
  logic [CW-1:0]        le_cnt;

  logic [TIME_BITS-1:0] end_mem [RING_DEPTH];
  logic [TIME_BITS-1:0] el_mem  [RING_DEPTH];
  logic [TIME_BITS-1:0] rd_end;
  logic [TIME_BITS-1:0] rd_el;

  logic                 accept;
  logic                 mem_we;
  result_t              fast_res;
  logic [TIME_BITS-1:0] age_sel;
  logic [TIME_BITS-1:0] cutoff_in;
  logic [CW:0]          hx;
  logic [CW:0]          cx;
  logic [AW-1:0]        tail;
  logic [AW-1:0]        ptr_inc;
  logic [CW-1:0]        idx_inc;
  logic                 last;
  logic [TIME_BITS-1:0] probe;
  logic [CW-1:0]        le_new;
  logic [RW-1:0]        rank_num;
  logic [RW+MW-1:0]     rank_prod;
  logic [CW-1:0]        rank_q;
  logic                 done_next;

  logic                 div_go;
  logic [DW-1:0]        div_a;
  logic [VW-1:0]        div_b;
  logic                 div_done;
  logic [DW-1:0]        div_q;

  // shared helpers
  always_comb begin
    accept    = start && !busy;
    mem_we    = accept && (item.cmd == CMD_END) && (open_start != '0);
    // start and end answer at once: only the accepted flag can be set
    fast_res          = '0;
    fast_res.accepted = (item.cmd == CMD_START) ? (open_start == '0) : mem_we;
    age_sel   = (item.cmd == CMD_CULL) ? keep_age : item.window_age;
    cutoff_in = (item.time_stamp > age_sel) ? item.time_stamp - age_sel : '0;
    hx        = (CW+1)'(head);
    cx        = (CW+1)'(count);
    tail      = AW'((hx >= cx) ? hx - cx : hx + (CW+1)'(RING_DEPTH) - cx);
    ptr_inc   = (ptr == AW'(RING_DEPTH - 1)) ? '0 : ptr + 1'b1;
    idx_inc   = idx + 1'b1;
    last      = (idx_inc == nwin);
    probe     = ans | (pbit - 1'b1);
    le_new    = le_cnt + CW'(rd_el <= probe);
    rank_num  = RW'(nwin) * RW'(PCT_NUM);
    rank_prod = (RW+MW)'(rank_num) * (RW+MW)'(RMUL);
    rank_q    = CW'(rank_prod >> RS);
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && (item.cmd == CMD_CULL || item.cmd == CMD_QUERY)) begin
          state_next = ST_SCAN_RD;
        end
      end
      ST_SCAN_RD:   state_next = (idx == count) ? ST_SCAN_END : ST_SCAN_CHK;
      ST_SCAN_CHK:  state_next = (rd_end >= cutoff) ? ST_SCAN_END : ST_SCAN_RD;
      ST_SCAN_END: begin
        if (cmd_r == CMD_CULL || count == idx) begin
          state_next = ST_IDLE;
        end else begin
          state_next = ST_STAT_RD;
        end
      end
      ST_STAT_RD:   state_next = ST_STAT_ACC;
      ST_STAT_ACC:  state_next = last ? ST_RANK_GO : ST_STAT_RD;
      ST_RANK_GO:   state_next = ST_PCT_RD;
      ST_PCT_RD:    state_next = ST_PCT_ACC;
      ST_PCT_ACC:   state_next = (last && pbit[0]) ? ST_AVG_GO : ST_PCT_RD;
      ST_AVG_GO:    state_next = ST_AVG_WAIT;
      ST_AVG_WAIT:  state_next = div_done ? ST_IDLE : ST_AVG_WAIT;
      default:      state_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer: handshake, result strobe and divider operands
  always_comb begin
    busy      = (state != ST_IDLE);
    done_next = (accept && (item.cmd == CMD_START || item.cmd == CMD_END)) ||
                ((state == ST_SCAN_END) && (cmd_r == CMD_CULL || count == idx)) ||
                ((state == ST_AVG_WAIT) && div_done);
    div_go    = (state == ST_AVG_GO);
    div_a     = {sum, 8'b0};
    div_b     = VW'(nwin);
  end

  lws_div #(
    .DW(DW),
    .VW(VW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .go       (div_go),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quotient (div_q)
  );

  // ring storage: one write at head, one registered read at ptr
  always_ff @(posedge clk) begin
    if (mem_we) begin
      end_mem[head] <= item.time_stamp;
      el_mem[head]  <= item.time_stamp - open_start;
    end
    rd_end <= end_mem[ptr];
    rd_el  <= el_mem[ptr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      keep_age   <= KEEP_AGE_RESET;
      open_start <= '0;
      head       <= '0;
      count      <= '0;
      done       <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
      if (cfg_we) begin
        keep_age <= cfg_wdata;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            cmd_r  <= item.cmd;
            cutoff <= cutoff_in;
            ptr    <= tail;
            idx    <= '0;
            result <= fast_res;
            if (item.cmd == CMD_START) begin
              if (open_start == '0) begin
                open_start <= item.time_stamp;
              end
            end else if (item.cmd == CMD_END) begin
              if (mem_we) begin
                head       <= (head == AW'(RING_DEPTH - 1)) ? '0 : head + 1'b1;
                count      <= (count == CW'(RING_DEPTH)) ? count : count + 1'b1;
                open_start <= '0;
              end
            end
          end
        end
        ST_SCAN_CHK: begin
          // advance until the first entry ending at or after the cutoff
          if (rd_end < cutoff) begin
            idx <= idx_inc;
            ptr <= ptr_inc;
          end
        end
        ST_SCAN_END: begin
          nwin    <= count - idx;
          win_ptr <= ptr;
          mn      <= '1;
          mx      <= '0;
          sum     <= '0;
          idx     <= '0;
          if (cmd_r == CMD_CULL) begin
            count <= count - idx;
          end
        end
        ST_STAT_ACC: begin
          if (rd_el < mn) mn <= rd_el;
          if (rd_el > mx) mx <= rd_el;
          sum <= sum + SUMW'(rd_el);
          if (last) begin
            ptr    <= win_ptr;
            idx    <= '0;
            ans    <= '0;
            pbit   <= {1'b1, {(TIME_BITS-1){1'b0}}};
            le_cnt <= '0;
          end else begin
            idx <= idx_inc;
            ptr <= ptr_inc;
          end
        end
        ST_RANK_GO: begin
          rank <= rank_q;
        end
        ST_PCT_ACC: begin
          // count samples at or below the probe; settle one bit per pass
          if (last) begin
            if (le_new <= rank) begin
              ans <= ans | pbit;
            end
            pbit   <= pbit >> 1;
            ptr    <= win_ptr;
            idx    <= '0;
            le_cnt <= '0;
          end else begin
            le_cnt <= le_new;
            idx    <= idx_inc;
            ptr    <= ptr_inc;
          end
        end
        ST_AVG_WAIT: begin
          if (div_done) begin
            result.accepted      <= 1'b1;
            result.sample_count  <= SCNT_BITS'(nwin);
            result.min_elapsed   <= mn;
            result.max_elapsed   <= mx;
            result.average_fx    <= AVG_BITS'(div_q);
            result.pct95_elapsed <= ans;
          end
        end
        default: begin
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result word shown while busy");
  a_fast_cmd: assert property (@(posedge clk) disable iff (rst)
      (accept && (item.cmd == CMD_START || item.cmd == CMD_END)) |=> (done && !busy))
    else $error("start or end word did not finish in one cycle");
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
      count <= CW'(RING_DEPTH))
    else $error("ring count beyond depth");
  a_refused_zero: assert property (@(posedge clk) disable iff (rst)
      (done && !result.accepted) |-> (result.sample_count == '0))
    else $error("refused word carries a sample count");
`endif

endmodule

### rtl/lws_div.sv
// Iterative restoring divider, one quotient bit per clock.
// Does not import lws_pkg and uses none of its types.
module lws_div #(
  parameter int DW = 72,
  parameter int VW = 11
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          go,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int CNTW = $clog2(DW + 1);

  logic [DW-1:0]   quo;
  logic [VW-1:0]   rem;
  logic [VW-1:0]   dvs;
  logic [CNTW-1:0] cnt;
  logic            run;
  logic [VW:0]     rem_sh;
  logic            ge;
  logic [VW-1:0]   rem_next;

  always_comb begin
    rem_sh   = {rem, quo[DW-1]};
    ge       = (rem_sh >= {1'b0, dvs});
    rem_next = ge ? VW'(rem_sh - {1'b0, dvs}) : VW'(rem_sh);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= !go && run && (cnt == CNTW'(1));
      if (go) begin
        quo <= dividend;
        rem <= '0;
        dvs <= divisor;
        cnt <= CNTW'(DW);
        run <= 1'b1;
      end else if (run) begin
        // shift in one dividend bit, subtract when it fits
        rem <= rem_next;
        quo <= {quo[DW-2:0], ge};
        cnt <= cnt - 1'b1;
        if (cnt == CNTW'(1)) begin
          run <= 1'b0;
        end
      end
    end
  end

  assign quotient = quo;

endmodule

### tb/latency_window_statistics_tb.sv
// Self-checking testbench for latency_window_statistics: directed and random
// command words checked against an in-bench prediction of the sample ring.
// Depends on rtl/lws_pkg.sv, rtl/latency_window_statistics.sv and rtl/lws_div.sv.
`timescale 1ns / 100ps

module latency_window_statistics_tb;
  import lws_pkg::*;

  localparam int DEPTH = RING_DEPTH_DEF;
  localparam logic [TIME_BITS-1:0] TMAX = '1;
  localparam longint CYCLE_LIMIT = 4000000;
  // Cap on window size for random queries.
  localparam int QUERY_CAP = 32;

  // Ring of finished samples and the results they should produce.
  class latency_ledger;
    logic [TIME_BITS-1:0] keep_age;
    logic [TIME_BITS-1:0] open_start;
    logic [TIME_BITS-1:0] end_stamp [DEPTH];
    logic [TIME_BITS-1:0] elapsed [DEPTH];
    int unsigned head;
    int unsigned count;
    result_t expected_q[$];
    int mismatches;
    bit failed;

    function new();
      keep_age = KEEP_AGE_RESET;
      open_start = '0;
      head = 0;
      count = 0;
      mismatches = 0;
      failed = 0;
    endfunction

    function int unsigned slot(int unsigned k);
      return (head + DEPTH - count + k) % DEPTH;
    endfunction

    // Number of oldest samples ahead of the first that ends at or after cutoff.
    function int unsigned stale_count(logic [TIME_BITS-1:0] now,
                                      logic [TIME_BITS-1:0] age);
      logic [TIME_BITS-1:0] cutoff;
      cutoff = (now > age) ? now - age : '0;
      for (int unsigned k = 0; k < count; k++)
        if (end_stamp[slot(k)] >= cutoff) return k;
      return count;
    endfunction

    function int unsigned window_count(logic [TIME_BITS-1:0] now,
                                       logic [TIME_BITS-1:0] age);
      return count - stale_count(now, age);
    endfunction

    // Advance the ring by one accepted word and queue the result it causes.
    function void note(item_t it);
      result_t r;
      int unsigned skip, n;
      logic [TIME_BITS-1:0] mn, mx, e;
      logic [79:0] sum;
      logic [79:0] avg;
      logic [TIME_BITS-1:0] vals[$];
      r = '0;
      case (it.cmd)
        CMD_START: begin
          if (open_start == '0) begin
            open_start = it.time_stamp;
            r.accepted = 1'b1;
          end
        end
        CMD_END: begin
          if (open_start != '0) begin
            end_stamp[head] = it.time_stamp;
            elapsed[head] = it.time_stamp - open_start;
            head = (head + 1) % DEPTH;
            if (count < DEPTH) count++;
            open_start = '0;
            r.accepted = 1'b1;
          end
        end
        CMD_CULL: count -= stale_count(it.time_stamp, keep_age);
        default: begin
          skip = stale_count(it.time_stamp, it.window_age);
          n = count - skip;
          if (n != 0) begin
            mn = TMAX;
            mx = '0;
            sum = '0;
            for (int unsigned k = 0; k < n; k++) begin
              e = elapsed[slot(skip + k)];
              vals.push_back(e);
              if (e < mn) mn = e;
              if (e > mx) mx = e;
              sum += e;
            end
            avg = (sum << 8) / n;
            vals.sort();
            r.accepted = 1'b1;
            r.sample_count = n[SCNT_BITS-1:0];
            r.min_elapsed = mn;
            r.max_elapsed = mx;
            r.average_fx = avg[AVG_BITS-1:0];
            r.pct95_elapsed = vals[(n * PCT_NUM) / PCT_DEN];
          end
        end
      endcase
      expected_q.push_back(r);
    endfunction

    function void check(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        failed = 1;
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h", got);
        return;
      end
      want = expected_q.pop_front();
      if (got.accepted !== want.accepted || got.sample_count !== want.sample_count ||
          got.min_elapsed !== want.min_elapsed || got.max_elapsed !== want.max_elapsed ||
          got.average_fx !== want.average_fx ||
          got.pct95_elapsed !== want.pct95_elapsed) begin
        failed = 1;
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: acc %0d/%0d cnt %0d/%0d min %0d/%0d max %0d/%0d avg %0d/%0d p95 %0d/%0d",
                   want.accepted, got.accepted, want.sample_count, got.sample_count,
                   want.min_elapsed, got.min_elapsed, want.max_elapsed, got.max_elapsed,
                   want.average_fx, got.average_fx, want.pct95_elapsed, got.pct95_elapsed);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  item_t item = '0;
  logic busy;
  logic done;
  result_t result;
  logic cfg_we = 1'b0;
  logic [TIME_BITS-1:0] cfg_wdata = '0;

  latency_window_statistics dut (
    .clk(clk), .rst(rst), .start(start), .item(item), .busy(busy),
    .done(done), .result(result), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  latency_ledger ledger = new();
  int idle_pct = 0;
  logic [TIME_BITS-1:0] now_t = TIME_BITS'(1000);
  longint cycles = 0;

  always #4 clk = ~clk;

  // Every done cycle carries one result word; the receiver cannot stall.
  always @(posedge clk) begin
    if (!rst && done) ledger.check(result);
  end

  // Hard stop for a hung block.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic logic [TIME_BITS-1:0] rand_time();
    logic [63:0] v;
    v = {$urandom, $urandom};
    return v[TIME_BITS-1:0];
  endfunction

  // Present one command word; busy is stable between edges, so sample it at
  // the falling edge to know whether the next rising edge takes the word.
  task automatic send(cmd_t c, logic [TIME_BITS-1:0] ts, logic [TIME_BITS-1:0] win);
    item_t it;
    it.cmd = c;
    it.time_stamp = ts;
    it.window_age = win;
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk);
    end
    @(negedge clk);
    start <= 1'b1;
    item <= it;
    while (busy) @(negedge clk);
    @(posedge clk);
    ledger.note(it);
  endtask

  // Hold until every expected word is back and the block is idle.
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (ledger.expected_q.size() != 0 || busy) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_keep_age(logic [TIME_BITS-1:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    ledger.keep_age = v;
  endtask

  // One random step: mostly well-formed start/end pairs, plus cull, query and noise.
  task automatic random_step();
    int unsigned pick;
    logic [TIME_BITS-1:0] ts, win;
    pick = $urandom_range(0, 99);
    now_t += TIME_BITS'($urandom_range(1, 5000));
    if (pick < 70) begin
      if (ledger.open_start == '0) send(CMD_START, now_t, rand_time());
      else send(CMD_END, now_t, rand_time());
    end else if (pick < 80) begin
      send(CMD_CULL, ($urandom_range(0, 3) == 0) ? rand_time() : now_t, rand_time());
    end else if (pick < 87) begin
      ts = ($urandom_range(0, 3) == 0) ? rand_time() : now_t;
      win = ($urandom_range(0, 2) == 0) ? rand_time() :
            TIME_BITS'($urandom_range(0, 60000));
      if (ledger.window_count(ts, win) > QUERY_CAP) begin
        ts = TMAX;
        win = '0;
      end
      if (ledger.window_count(ts, win) > QUERY_CAP) send(CMD_CULL, now_t, win);
      else send(CMD_QUERY, ts, win);
    end else begin
      // Noise: refused words, time zero, ends before starts, random times.
      ts = ($urandom_range(0, 3) == 0) ? '0 : rand_time();
      send(($urandom_range(0, 1) == 0) ? CMD_START : CMD_END, ts, rand_time());
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed opening: refusals, time zero, wrap, saturation, cull.
    write_keep_age(KEEP_AGE_RESET);
    send(CMD_END, 48'd5, '0);
    send(CMD_START, '0, '0);
    send(CMD_QUERY, 48'd100, TMAX);
    send(CMD_START, 48'd100, '0);
    send(CMD_START, 48'd200, '0);
    send(CMD_END, 48'd50, '0);
    send(CMD_START, 48'd10, '0);
    send(CMD_END, 48'd300, '0);
    send(CMD_QUERY, 48'd300, '0);
    send(CMD_QUERY, TMAX, TMAX);
    send(CMD_QUERY, 48'd10, 48'd100);
    send(CMD_START, TMAX, TMAX);
    send(CMD_END, TMAX, TMAX);
    send(CMD_QUERY, TMAX, 48'd1);
    send(CMD_CULL, 48'd700000, '0);
    send(CMD_QUERY, '0, '0);
    write_keep_age(48'd1);
    send(CMD_CULL, TMAX, '0);
    send(CMD_QUERY, '0, '0);
    send(CMD_CULL, TMAX, TMAX);
    send(CMD_QUERY, '0, TMAX);

    // Overfill the ring so the oldest entries get overwritten, then query it whole.
    write_keep_age(TMAX);
    for (int i = 0; i < DEPTH + 6; i++) begin
      now_t += TIME_BITS'($urandom_range(1, 300));
      send(CMD_START, now_t, '0);
      now_t += TIME_BITS'($urandom_range(1, 300));
      send(CMD_END, now_t, '0);
    end
    send(CMD_CULL, TMAX, '0);
    send(CMD_QUERY, '0, '0);
    write_keep_age(48'd1);
    send(CMD_CULL, TMAX, '0);

    // Random phases across keep_age settings and sender idle rates.
    for (int phase = 0; phase < 6; phase++) begin
      case (phase % 3)
        0: idle_pct = 17;
        1: idle_pct = 65;
        default: idle_pct = 0;
      endcase
      case (phase)
        0: write_keep_age(KEEP_AGE_RESET);
        1: write_keep_age(48'd1);
        2: write_keep_age(48'd20000);
        3: write_keep_age(TMAX);
        4: write_keep_age(rand_time());
        default: write_keep_age(48'd200000);
      endcase
      for (int i = 0; i < 250; i++) begin
        random_step();
        // Keep the ring short so queries stay cheap.
        if (ledger.count > 200) send(CMD_CULL, TMAX, '0);
      end
    end

    drain();
    repeat (50) @(negedge clk);
    if (!ledger.failed && ledger.expected_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### sim.f
rtl/lws_pkg.sv
rtl/lws_div.sv
rtl/latency_window_statistics.sv
tb/latency_window_statistics_tb.sv
